// ===== rtl/twtl_pkg.sv =====
// ----------------------------------------------------------------------------
// twtl_pkg
// shared types, codes and the digit decoder for the two-way traffic light
// display core
// ----------------------------------------------------------------------------
package twtl_pkg;

    localparam int CountW    = 7;
    localparam int PhaseW    = 2;
    localparam int ModeW     = 2;
    localparam int DigitW    = 4;
    localparam int SegW      = 7;
    localparam int DigitNum  = 5;
    localparam int ScanW     = 3;
    localparam int CfgIndexW = 3;

    typedef logic [CountW-1:0] count_t;
    typedef logic [PhaseW-1:0] phase_t;
    typedef logic [SegW-1:0]   seg_t;

    // lamp phases
    localparam phase_t PH_RED    = 2'd0;
    localparam phase_t PH_YELLOW = 2'd1;
    localparam phase_t PH_GREEN  = 2'd2;

    // event kinds
    localparam logic [ModeW-1:0] EV_TICK   = 2'd0;
    localparam logic [ModeW-1:0] EV_SCAN   = 2'd1;
    localparam logic [ModeW-1:0] EV_RELOAD = 2'd2;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_RED_TIME    = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_GREEN_TIME  = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_YELLOW_TIME = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_RED_START   = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_GREEN_START = 3'd4;

    // scan positions
    localparam logic [ScanW-1:0] SCAN_A_TENS  = 3'd0;
    localparam logic [ScanW-1:0] SCAN_A_UNITS = 3'd1;
    localparam logic [ScanW-1:0] SCAN_B_TENS  = 3'd2;
    localparam logic [ScanW-1:0] SCAN_B_UNITS = 3'd3;
    localparam logic [ScanW-1:0] SCAN_MODE    = 3'd4;

    // register reset values
    localparam count_t RED_TIME_RST    = 7'd5;
    localparam count_t GREEN_TIME_RST  = 7'd3;
    localparam count_t YELLOW_TIME_RST = 7'd2;
    localparam count_t RED_START_RST   = 7'd5;
    localparam count_t GREEN_START_RST = 7'd3;

    localparam seg_t BLANK_SEG = 7'h7f;

    // divide by ten via reciprocal, exact for values below 1029
    localparam logic [7:0] RECIP_TEN = 8'd205;
    localparam int         RECIP_SH  = 11;

    // active-low seven-segment pattern, blank above nine
    function automatic seg_t seg_decode(input logic [DigitW-1:0] v);
        seg_t s;
        unique case (v)
            4'd0:    s = 7'h40;
            4'd1:    s = 7'h79;
            4'd2:    s = 7'h24;
            4'd3:    s = 7'h30;
            4'd4:    s = 7'h19;
            4'd5:    s = 7'h12;
            4'd6:    s = 7'h02;
            4'd7:    s = 7'h78;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h10;
            default: s = BLANK_SEG;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/two_way_traffic_light_display_core.sv =====
// ----------------------------------------------------------------------------
// two_way_traffic_light_display_core
// two-direction traffic light with countdowns and a multiplexed five-digit
// seven-segment readout
// ----------------------------------------------------------------------------
// data path: an accepted event is held in the input stage register, then moves
// into the result register once that register is free or being drained
// throughput: one item per cycle while out_ready holds, set by the single input and
// result register stages; the input stage refills while the result register drains
// reset (rst_n low): registers to their defaults, A red with 5, B green with 3,
// display blank, all enables off, no item held in either stage
module two_way_traffic_light_display_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [twtl_pkg::ModeW-1:0]          mode,
    input  logic [twtl_pkg::DigitW-1:0]         shown_mode_digit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [twtl_pkg::PhaseW-1:0]         lamp_a,
    output logic [twtl_pkg::PhaseW-1:0]         lamp_b,
    output logic [twtl_pkg::SegW-1:0]           segments,
    output logic [twtl_pkg::DigitNum-1:0]       digit_enable,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twtl_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [twtl_pkg::CountW-1:0]         cfg_data
);

    // configuration
    twtl_pkg::count_t red_time_reg, green_time_reg, yellow_time_reg;
    twtl_pkg::count_t red_start_reg, green_start_reg;

    // input stage
    logic                          in_vld_reg;
    logic [twtl_pkg::ModeW-1:0]    mode_reg;
    logic [twtl_pkg::DigitW-1:0]   mdig_reg;

    // state
    twtl_pkg::count_t              cnt_a_reg, cnt_a_next;
    twtl_pkg::count_t              cnt_b_reg, cnt_b_next;
    twtl_pkg::phase_t              ph_a_reg, ph_a_next;
    twtl_pkg::phase_t              ph_b_reg, ph_b_next;
    logic [twtl_pkg::ScanW-1:0]    scan_pos_reg, scan_pos_next;
    twtl_pkg::seg_t                seg_reg, seg_next;
    logic [twtl_pkg::DigitNum-1:0] en_reg, en_next;

    // result stage
    logic                          out_vld_reg;
    twtl_pkg::phase_t              lamp_a_reg, lamp_b_reg;
    twtl_pkg::seg_t                out_seg_reg;
    logic [twtl_pkg::DigitNum-1:0] out_en_reg;

    logic                          advance;
    twtl_pkg::count_t              scan_cnt;
    logic [14:0]                   prod;
    logic [3:0]                    tens;
    twtl_pkg::count_t              units;
    logic [twtl_pkg::DigitW-1:0]   scan_val;

    function automatic twtl_pkg::count_t reload_of(input twtl_pkg::count_t t);
        return (t == '0) ? '0 : t - 7'd1;
    endfunction

    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_vld_reg;
    assign lamp_a       = lamp_a_reg;
    assign lamp_b       = lamp_b_reg;
    assign segments     = out_seg_reg;
    assign digit_enable = out_en_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_time_reg    <= twtl_pkg::RED_TIME_RST;
            green_time_reg  <= twtl_pkg::GREEN_TIME_RST;
            yellow_time_reg <= twtl_pkg::YELLOW_TIME_RST;
            red_start_reg   <= twtl_pkg::RED_START_RST;
            green_start_reg <= twtl_pkg::GREEN_START_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                twtl_pkg::CFG_RED_TIME:    red_time_reg    <= cfg_data;
                twtl_pkg::CFG_GREEN_TIME:  green_time_reg  <= cfg_data;
                twtl_pkg::CFG_YELLOW_TIME: yellow_time_reg <= cfg_data;
                twtl_pkg::CFG_RED_START:   red_start_reg   <= cfg_data;
                twtl_pkg::CFG_GREEN_START: green_start_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            mdig_reg <= shown_mode_digit;
        end
    end

    // digit value for the current scan position
    always_comb
    begin
        scan_cnt = (scan_pos_reg == twtl_pkg::SCAN_B_TENS ||
                    scan_pos_reg == twtl_pkg::SCAN_B_UNITS) ? cnt_b_reg : cnt_a_reg;
        prod  = 15'(scan_cnt) * 15'(twtl_pkg::RECIP_TEN);
        tens  = prod[14:twtl_pkg::RECIP_SH];
        units = scan_cnt - 7'(tens) * 7'd10;
        unique case (scan_pos_reg)
            twtl_pkg::SCAN_A_TENS,
            twtl_pkg::SCAN_B_TENS:  scan_val = tens;
            twtl_pkg::SCAN_A_UNITS,
            twtl_pkg::SCAN_B_UNITS: scan_val = units[3:0];
            default:                scan_val = mdig_reg;
        endcase
    end

    // next state
    always_comb
    begin
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        ph_a_next     = ph_a_reg;
        ph_b_next     = ph_b_reg;
        scan_pos_next = scan_pos_reg;
        seg_next      = seg_reg;
        en_next       = en_reg;
        unique case (mode_reg)
            twtl_pkg::EV_TICK:
            begin
                if (cnt_a_reg != '0)
                begin
                    cnt_a_next = cnt_a_reg - 7'd1;
                end
                else
                begin
                    unique case (ph_a_reg)
                        twtl_pkg::PH_RED:
                        begin
                            ph_a_next  = twtl_pkg::PH_GREEN;
                            cnt_a_next = reload_of(green_time_reg);
                        end
                        twtl_pkg::PH_GREEN:
                        begin
                            ph_a_next  = twtl_pkg::PH_YELLOW;
                            cnt_a_next = reload_of(yellow_time_reg);
                        end
                        twtl_pkg::PH_YELLOW:
                        begin
                            ph_a_next  = twtl_pkg::PH_RED;
                            cnt_a_next = reload_of(red_time_reg);
                        end
                        default: ;
                    endcase
                end
                if (cnt_b_reg != '0)
                begin
                    cnt_b_next = cnt_b_reg - 7'd1;
                end
                else
                begin
                    unique case (ph_b_reg)
                        twtl_pkg::PH_RED:
                        begin
                            ph_b_next  = twtl_pkg::PH_GREEN;
                            cnt_b_next = reload_of(green_time_reg);
                        end
                        twtl_pkg::PH_GREEN:
                        begin
                            ph_b_next  = twtl_pkg::PH_YELLOW;
                            cnt_b_next = reload_of(yellow_time_reg);
                        end
                        twtl_pkg::PH_YELLOW:
                        begin
                            ph_b_next  = twtl_pkg::PH_RED;
                            cnt_b_next = reload_of(red_time_reg);
                        end
                        default: ;
                    endcase
                end
            end
            twtl_pkg::EV_SCAN:
            begin
                if (scan_pos_reg <= twtl_pkg::SCAN_MODE)
                begin
                    seg_next      = twtl_pkg::seg_decode(scan_val);
                    en_next       = 5'b00001 << scan_pos_reg;
                    scan_pos_next = (scan_pos_reg == twtl_pkg::SCAN_MODE) ?
                                    twtl_pkg::SCAN_A_TENS : scan_pos_reg + 3'd1;
                end
            end
            twtl_pkg::EV_RELOAD:
            begin
                cnt_a_next = red_start_reg;
                cnt_b_next = green_start_reg;
                ph_a_next  = twtl_pkg::PH_RED;
                ph_b_next  = twtl_pkg::PH_GREEN;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg    <= twtl_pkg::RED_START_RST;
            cnt_b_reg    <= twtl_pkg::GREEN_START_RST;
            ph_a_reg     <= twtl_pkg::PH_RED;
            ph_b_reg     <= twtl_pkg::PH_GREEN;
            scan_pos_reg <= twtl_pkg::SCAN_A_TENS;
            seg_reg      <= twtl_pkg::BLANK_SEG;
            en_reg       <= '0;
        end
        else if (advance)
        begin
            cnt_a_reg    <= cnt_a_next;
            cnt_b_reg    <= cnt_b_next;
            ph_a_reg     <= ph_a_next;
            ph_b_reg     <= ph_b_next;
            scan_pos_reg <= scan_pos_next;
            seg_reg      <= seg_next;
            en_reg       <= en_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lamp_a_reg  <= ph_a_next;
            lamp_b_reg  <= ph_b_next;
            out_seg_reg <= seg_next;
            out_en_reg  <= en_next;
        end
    end

    a_en_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> $onehot0(out_en_reg))
        else $error("digit enable not one-hot");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_pos_reg <= twtl_pkg::SCAN_MODE)
        else $error("scan position out of range");

    a_lamp_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (lamp_a_reg != 2'd3 && lamp_b_reg != 2'd3))
        else $error("unused lamp code shown");

    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == twtl_pkg::EV_RELOAD) |=>
        (lamp_a_reg == twtl_pkg::PH_RED && lamp_b_reg == twtl_pkg::PH_GREEN &&
         cnt_a_reg == $past(red_start_reg)))
        else $error("reload did not restore start state");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> in_ready)
        else $error("input stalled with empty result stage");

endmodule

// ===== verif/two_way_traffic_light_display_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_way_traffic_light_display_checker
// watches the event, result and register channels of the traffic light core,
// keeps its own copy of lamps, countdowns and readout, and compares every
// result transfer field by field with the oldest predicted lamp view
// ----------------------------------------------------------------------------
module two_way_traffic_light_display_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [twtl_pkg::ModeW-1:0]       mode,
    input  logic [twtl_pkg::DigitW-1:0]      shown_mode_digit,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [twtl_pkg::PhaseW-1:0]      lamp_a,
    input  logic [twtl_pkg::PhaseW-1:0]      lamp_b,
    input  logic [twtl_pkg::SegW-1:0]        segments,
    input  logic [twtl_pkg::DigitNum-1:0]    digit_enable,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [twtl_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [twtl_pkg::CountW-1:0]      cfg_data,
    output int                               fail_count,
    output int                               pending
);

    localparam int RADIX = 10;
    localparam int DIG_W = twtl_pkg::DigitW;
    localparam int EN_W  = twtl_pkg::DigitNum;
    // active-low glyphs for 9 down to 0
    localparam logic [10*twtl_pkg::SegW-1:0] GLYPHS = {
        7'h10, 7'h00, 7'h78, 7'h02, 7'h12, 7'h19, 7'h30, 7'h24, 7'h79, 7'h40
    };

    typedef struct packed {
        twtl_pkg::phase_t                lamp_a;
        twtl_pkg::phase_t                lamp_b;
        twtl_pkg::seg_t                  segments;
        logic [twtl_pkg::DigitNum-1:0]   digit_enable;
    } lamp_view_t;

    twtl_pkg::count_t red_len, green_len, yellow_len, a_start, b_start;
    twtl_pkg::count_t count_a, count_b;
    twtl_pkg::phase_t light_a, light_b;
    logic [twtl_pkg::ScanW-1:0] scan_pos;
    twtl_pkg::seg_t held_segs;
    logic [twtl_pkg::DigitNum-1:0] held_enables;
    logic [twtl_pkg::DigitW-1:0] digit_val;
    lamp_view_t expected_views[$];
    lamp_view_t want;

    function automatic twtl_pkg::count_t phase_reload(input twtl_pkg::count_t len);
        return (len == '0) ? '0 : len - 1'b1;
    endfunction

    function automatic twtl_pkg::seg_t glyph(input logic [twtl_pkg::DigitW-1:0] v);
        return (v < RADIX) ? GLYPHS[v*twtl_pkg::SegW +: twtl_pkg::SegW]
                           : twtl_pkg::BLANK_SEG;
    endfunction

    task automatic advance(inout twtl_pkg::count_t cnt, inout twtl_pkg::phase_t ph);
        if (cnt != '0)
        begin
            cnt = cnt - 1'b1;
        end
        else
        begin
            case (ph)
                twtl_pkg::PH_RED:
                begin
                    ph  = twtl_pkg::PH_GREEN;
                    cnt = phase_reload(green_len);
                end
                twtl_pkg::PH_GREEN:
                begin
                    ph  = twtl_pkg::PH_YELLOW;
                    cnt = phase_reload(yellow_len);
                end
                twtl_pkg::PH_YELLOW:
                begin
                    ph  = twtl_pkg::PH_RED;
                    cnt = phase_reload(red_len);
                end
                default: ;
            endcase
        end
    endtask

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_len      = twtl_pkg::RED_TIME_RST;
            green_len    = twtl_pkg::GREEN_TIME_RST;
            yellow_len   = twtl_pkg::YELLOW_TIME_RST;
            a_start      = twtl_pkg::RED_START_RST;
            b_start      = twtl_pkg::GREEN_START_RST;
            count_a      = twtl_pkg::RED_START_RST;
            count_b      = twtl_pkg::GREEN_START_RST;
            light_a      = twtl_pkg::PH_RED;
            light_b      = twtl_pkg::PH_GREEN;
            scan_pos     = twtl_pkg::SCAN_A_TENS;
            held_segs    = twtl_pkg::BLANK_SEG;
            held_enables = '0;
            expected_views.delete();
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    twtl_pkg::CFG_RED_TIME:    red_len    = cfg_data;
                    twtl_pkg::CFG_GREEN_TIME:  green_len  = cfg_data;
                    twtl_pkg::CFG_YELLOW_TIME: yellow_len = cfg_data;
                    twtl_pkg::CFG_RED_START:   a_start    = cfg_data;
                    twtl_pkg::CFG_GREEN_START: b_start    = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result transfer with nothing expected, actual %h %h %h %h",
                             $time, lamp_a, lamp_b, segments, digit_enable);
                end
                else
                begin
                    want = expected_views.pop_front();
                    report_field("lamp_a", int'(want.lamp_a), int'(lamp_a));
                    report_field("lamp_b", int'(want.lamp_b), int'(lamp_b));
                    report_field("segments", int'(want.segments), int'(segments));
                    report_field("digit_enable", int'(want.digit_enable),
                                 int'(digit_enable));
                end
            end

            if (in_valid && in_ready)
            begin
                case (mode)
                    twtl_pkg::EV_TICK:
                    begin
                        advance(count_a, light_a);
                        advance(count_b, light_b);
                    end
                    twtl_pkg::EV_SCAN:
                    begin
                        if (scan_pos <= twtl_pkg::SCAN_MODE)
                        begin
                            case (scan_pos)
                                twtl_pkg::SCAN_A_TENS:  digit_val = DIG_W'(count_a / RADIX);
                                twtl_pkg::SCAN_A_UNITS: digit_val = DIG_W'(count_a % RADIX);
                                twtl_pkg::SCAN_B_TENS:  digit_val = DIG_W'(count_b / RADIX);
                                twtl_pkg::SCAN_B_UNITS: digit_val = DIG_W'(count_b % RADIX);
                                default:                digit_val = shown_mode_digit;
                            endcase
                            held_segs    = glyph(digit_val);
                            held_enables = EN_W'(1) << scan_pos;
                            scan_pos     = (scan_pos == twtl_pkg::SCAN_MODE) ?
                                           twtl_pkg::SCAN_A_TENS : scan_pos + 1'b1;
                        end
                    end
                    twtl_pkg::EV_RELOAD:
                    begin
                        count_a = a_start;
                        count_b = b_start;
                        light_a = twtl_pkg::PH_RED;
                        light_b = twtl_pkg::PH_GREEN;
                    end
                    default: ;
                endcase
                expected_views.push_back('{light_a, light_b, held_segs, held_enables});
            end
            pending = expected_views.size();
        end
    end

endmodule

// ===== verif/two_way_traffic_light_display_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_way_traffic_light_display_core_tb
// drives tick, scan, reload and unused events into the traffic light core
// under several register settings and idle patterns, with one long result
// hold-off; a checker beside the core predicts and compares every result
// ----------------------------------------------------------------------------
module two_way_traffic_light_display_core_tb;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 3;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SEG_ITEMS    = 140;
    localparam int DRAIN_CYCLES = 4;
    localparam int DIG_W        = twtl_pkg::DigitW;
    localparam logic [twtl_pkg::ModeW-1:0] EV_IGNORED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [twtl_pkg::ModeW-1:0] mode;
    logic [twtl_pkg::DigitW-1:0] shown_mode_digit;
    logic out_valid;
    logic out_ready;
    logic [twtl_pkg::PhaseW-1:0] lamp_a;
    logic [twtl_pkg::PhaseW-1:0] lamp_b;
    logic [twtl_pkg::SegW-1:0] segments;
    logic [twtl_pkg::DigitNum-1:0] digit_enable;
    logic cfg_valid;
    logic cfg_ready;
    logic [twtl_pkg::CfgIndexW-1:0] cfg_index;
    logic [twtl_pkg::CountW-1:0] cfg_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int fail_count;
    int pending;

    two_way_traffic_light_display_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .shown_mode_digit (shown_mode_digit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .lamp_a           (lamp_a),
        .lamp_b           (lamp_b),
        .segments         (segments),
        .digit_enable     (digit_enable),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    two_way_traffic_light_display_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .shown_mode_digit (shown_mode_digit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .lamp_a           (lamp_a),
        .lamp_b           (lamp_b),
        .segments         (segments),
        .digit_enable     (digit_enable),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int held;
        held = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                out_ready <= 1'b0;
                held++;
                if (held >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** two_way_traffic_light_display_core: FAILED **");
        $finish;
    end

    function automatic twtl_pkg::count_t rand_len(input int lo, input int hi);
        return twtl_pkg::count_t'($urandom_range(hi, lo));
    endfunction

    task automatic send_event(input logic [twtl_pkg::ModeW-1:0] kind,
                              input logic [twtl_pkg::DigitW-1:0] digit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        mode             <= kind;
        shown_mode_digit <= digit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        int pick;
        logic [twtl_pkg::ModeW-1:0] kind;
        pick = $urandom_range(99);
        if (pick < 50)
            kind = twtl_pkg::EV_TICK;
        else if (pick < 88)
            kind = twtl_pkg::EV_SCAN;
        else if (pick < 92)
            kind = twtl_pkg::EV_RELOAD;
        else
            kind = EV_IGNORED;
        send_event(kind, DIG_W'($urandom_range(15)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_setting(input twtl_pkg::count_t red_t, input twtl_pkg::count_t green_t,
                                 input twtl_pkg::count_t yellow_t,
                                 input twtl_pkg::count_t red_s,
                                 input twtl_pkg::count_t green_s);
        twtl_pkg::count_t vals [twtl_pkg::DigitNum];
        logic [twtl_pkg::CfgIndexW-1:0] idx [twtl_pkg::DigitNum];
        idx[0]  = twtl_pkg::CFG_RED_TIME;
        idx[1]  = twtl_pkg::CFG_GREEN_TIME;
        idx[2]  = twtl_pkg::CFG_YELLOW_TIME;
        idx[3]  = twtl_pkg::CFG_RED_START;
        idx[4]  = twtl_pkg::CFG_GREEN_START;
        vals[0] = red_t;
        vals[1] = green_t;
        vals[2] = yellow_t;
        vals[3] = red_s;
        vals[4] = green_s;
        for (int i = 0; i < twtl_pkg::DigitNum; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_segment(input int send_pct, input int recv_pct, input bit long_hold,
                               input twtl_pkg::count_t red_t, input twtl_pkg::count_t green_t,
                               input twtl_pkg::count_t yellow_t,
                               input twtl_pkg::count_t red_s,
                               input twtl_pkg::count_t green_s);
        drain();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_setting(red_t, green_t, yellow_t, red_s, green_s);
        if (long_hold)
            hold_go = 1'b1;
        repeat (SEG_ITEMS) send_random();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        mode             = twtl_pkg::EV_TICK;
        shown_mode_digit = '0;
        cfg_valid        = 1'b0;
        cfg_index        = twtl_pkg::CFG_RED_TIME;
        cfg_data         = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: blank readout, full scan, both lamps changing
        send_event(EV_IGNORED, 4'd15);
        for (int i = 0; i < twtl_pkg::DigitNum; i++)
            send_event(twtl_pkg::EV_SCAN, 4'd15);
        repeat (6) send_event(twtl_pkg::EV_TICK, 4'd0);
        for (int i = 0; i < twtl_pkg::DigitNum; i++)
            send_event(twtl_pkg::EV_SCAN, 4'd9);
        send_event(twtl_pkg::EV_RELOAD, 4'd0);

        // zero phase times and a wide countdown on A
        drain();
        write_setting(7'd0, 7'd0, 7'd0, 7'd127, 7'd1);
        send_event(twtl_pkg::EV_RELOAD, 4'd0);
        send_event(twtl_pkg::EV_SCAN, 4'd0);
        send_event(twtl_pkg::EV_SCAN, 4'd0);
        repeat (4) send_event(twtl_pkg::EV_TICK, 4'd0);

        run_segment(0, 0, 1'b1, rand_len(1, 9), rand_len(1, 9),
                    rand_len(1, 9), rand_len(1, 9), rand_len(1, 9));
        run_segment(0, 0, 1'b0, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99);
        run_segment(52, 0, 1'b0, rand_len(1, 99), rand_len(1, 99),
                    rand_len(1, 99), rand_len(1, 99), rand_len(1, 99));
        run_segment(52, 0, 1'b0, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
        run_segment(0, 52, 1'b0, rand_len(1, 9), rand_len(1, 9),
                    rand_len(1, 9), rand_len(1, 9), rand_len(1, 9));
        run_segment(0, 52, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd127);
        run_segment(6, 6, 1'b0, rand_len(1, 20), rand_len(1, 20),
                    rand_len(1, 20), rand_len(1, 20), rand_len(1, 20));
        run_segment(6, 6, 1'b0, rand_len(0, 127), rand_len(0, 127),
                    rand_len(0, 127), rand_len(0, 127), rand_len(0, 127));
        drain();

        if (fail_count == 0)
            $display("** two_way_traffic_light_display_core: PASSED **");
        else
            $display("** two_way_traffic_light_display_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/twtl_pkg.sv
rtl/two_way_traffic_light_display_core.sv
verif/two_way_traffic_light_display_checker.sv
verif/two_way_traffic_light_display_core_tb.sv
